// File: rtl/core/plde_pkg.sv
package plde_pkg;

  // operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_SKIP  = 2'd2;

  // header layout: post count, separator, document count, terminator
  localparam int unsigned POSTS_BYTES_I = 8;
  localparam int unsigned DOCS_BYTES_I  = 4;
  localparam logic [3:0]  POSTS_BYTES   = 4'(POSTS_BYTES_I);
  localparam logic [3:0]  HDR_LEN       = 4'(POSTS_BYTES_I + 1 + DOCS_BYTES_I + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_LOC_OR_FLAG = 2'd0,
    ROLE_DOC_DELTA   = 2'd1,
    ROLE_LOC_SET     = 2'd2
  } role_t;

  // byte classification done in the front end
  typedef struct packed {
    logic       is_cont;    // 10xxxxxx
    logic       bad_lead;   // continuation, 0xFE or 0xFF where a lead is expected
    logic [2:0] more;       // continuation bytes that follow a lead
    logic [6:0] lead_bits;  // payload bits of a lead
  } byte_class_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [31:0] target_doc;
    byte_class_t cls;
  } item_t;

  typedef struct packed {
    logic [31:0] doc_number;
    logic [31:0] location;
    logic        list_end;
    logic        malformed;
  } result_t;

endpackage

// File: rtl/core/plde_front.sv
module plde_front import plde_pkg::*; (
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic [31:0] target_doc,
  output item_t       item
);

  byte_class_t cls;

  always_comb begin
    cls = '0;
    case (data_byte) inside
      8'b0???????: begin
        cls.lead_bits = data_byte[6:0];
      end
      8'b10??????: begin
        cls.is_cont  = 1'b1;
        cls.bad_lead = 1'b1;
      end
      8'b110?????: begin
        cls.more      = 3'd1;
        cls.lead_bits = {2'b00, data_byte[4:0]};
      end
      8'b1110????: begin
        cls.more      = 3'd2;
        cls.lead_bits = {3'b000, data_byte[3:0]};
      end
      8'b11110???: begin
        cls.more      = 3'd3;
        cls.lead_bits = {4'b0000, data_byte[2:0]};
      end
      8'b111110??: begin
        cls.more      = 3'd4;
        cls.lead_bits = {5'b00000, data_byte[1:0]};
      end
      8'b1111110?: begin
        cls.more      = 3'd5;
        cls.lead_bits = {6'b000000, data_byte[0]};
      end
      default: begin
        cls.bad_lead = 1'b1;  // 0xFE, 0xFF
      end
    endcase
  end

  assign item = '{op: operation, data_byte: data_byte, target_doc: target_doc, cls: cls};

endmodule

// File: rtl/core/plde_queue.sv
module plde_queue import plde_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/plde_back.sv
module plde_back import plde_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] done_r, done_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cont_r, cont_nxt;
  role_t       role_r, role_nxt;
  logic [31:0] doc_r, doc_nxt;
  logic [31:0] loc_r, loc_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        emit;
  result_t     emit_res;
  logic        val_done;
  logic [31:0] val;
  logic        finished;
  logic        shown;
  logic [31:0] acc_shift;
  logic [63:0] done_inc;

  assign pop       = item_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign result    = res_r;

  assign acc_shift = {acc_r[25:0], item.data_byte[5:0]};
  assign done_inc  = done_r + 64'd1;
  // doc only moves on a doc delta, which never finishes a posting
  assign shown     = (doc_r >= skip_r);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    total_nxt   = total_r;
    done_nxt    = done_r;
    acc_nxt     = acc_r;
    cont_nxt    = cont_r;
    role_nxt    = role_r;
    doc_nxt     = doc_r;
    loc_nxt     = loc_r;
    skip_nxt    = skip_r;
    emit        = 1'b0;
    emit_res    = '0;
    val_done    = 1'b0;
    val         = '0;
    finished    = 1'b0;

    if (pop) begin
      case (item.op)
        OP_START: begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = '0;
          total_nxt   = '0;
          done_nxt    = '0;
          acc_nxt     = '0;
          cont_nxt    = '0;
          role_nxt    = ROLE_LOC_OR_FLAG;
          doc_nxt     = '0;
          loc_nxt     = '0;
          skip_nxt    = '0;
        end
        OP_SKIP: begin
          skip_nxt = item.target_doc;
        end
        OP_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              if (hdr_cnt_r < POSTS_BYTES) begin
                total_nxt[{hdr_cnt_r[2:0], 3'b000} +: 8] = item.data_byte;
              end
              hdr_cnt_nxt = hdr_cnt_r + 4'd1;
              if (hdr_cnt_nxt >= HDR_LEN) begin
                hdr_cnt_nxt = '0;
                if (total_r == '0) begin
                  phase_nxt = PH_DONE;
                  emit      = 1'b1;
                  emit_res  = '{doc_number: '0, location: '0, list_end: 1'b1,
                                malformed: 1'b0};
                end else begin
                  phase_nxt = PH_BODY;
                end
              end
            end
            PH_BODY: begin
              if (cont_r != '0) begin
                if (!item.cls.is_cont) begin
                  cont_nxt = '0;
                  acc_nxt  = '0;
                  emit     = 1'b1;
                  emit_res = '{doc_number: doc_r, location: loc_r, list_end: 1'b0,
                               malformed: 1'b1};
                end else begin
                  acc_nxt  = acc_shift;
                  cont_nxt = cont_r - 3'd1;
                  if (cont_nxt == '0) begin
                    val_done = 1'b1;
                    val      = acc_shift;
                  end
                end
              end else if (item.cls.bad_lead) begin
                emit     = 1'b1;
                emit_res = '{doc_number: doc_r, location: loc_r, list_end: 1'b0,
                             malformed: 1'b1};
              end else if (item.cls.more == '0) begin
                val_done = 1'b1;
                val      = {25'd0, item.cls.lead_bits};
              end else begin
                acc_nxt  = {25'd0, item.cls.lead_bits};
                cont_nxt = item.cls.more;
              end
            end
            default: begin
              // past the end of the list
              emit     = 1'b1;
              emit_res = '{doc_number: '0, location: '0, list_end: 1'b1, malformed: 1'b0};
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // completed value: apply by role
    if (val_done) begin
      case (role_r)
        ROLE_LOC_OR_FLAG: begin
          if (val != '0) begin
            loc_nxt  = loc_r + val;
            finished = 1'b1;
          end else begin
            role_nxt = ROLE_DOC_DELTA;
          end
        end
        ROLE_DOC_DELTA: begin
          doc_nxt  = doc_r + val;
          role_nxt = ROLE_LOC_SET;
        end
        default: begin
          loc_nxt  = val;
          role_nxt = ROLE_LOC_OR_FLAG;
          finished = 1'b1;
        end
      endcase
    end

    if (finished) begin
      done_nxt = done_inc;
      if (done_inc == total_r) begin
        phase_nxt = PH_DONE;
        emit      = 1'b1;
        if (shown) begin
          emit_res = '{doc_number: doc_nxt, location: loc_nxt, list_end: 1'b1,
                       malformed: 1'b0};
        end else begin
          emit_res = '{doc_number: '0, location: '0, list_end: 1'b1, malformed: 1'b0};
        end
      end else if (shown) begin
        emit     = 1'b1;
        emit_res = '{doc_number: doc_nxt, location: loc_nxt, list_end: 1'b0, malformed: 1'b0};
      end
    end

    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      total_r     <= '0;
      done_r      <= '0;
      acc_r       <= '0;
      cont_r      <= '0;
      role_r      <= ROLE_LOC_OR_FLAG;
      doc_r       <= '0;
      loc_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      acc_r       <= acc_nxt;
      cont_r      <= cont_nxt;
      role_r      <= role_nxt;
      doc_r       <= doc_nxt;
      loc_r       <= loc_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_hdr_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> cont_r == '0 && done_r == '0)
    else $error("partial value or posting count during header");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r < HDR_LEN)
    else $error("header byte count out of range");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> done_r < total_r)
    else $error("body phase with all postings consumed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(out_valid_r && out_stall))
    else $error("item retired while result slot is held");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && !(pop && item.op == OP_START) |=> phase_r == PH_DONE)
    else $error("left done phase without a start");

endmodule

// File: rtl/core/posting_list_delta_decoder_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_operation, in_data_byte, in_target_doc
// out      output     out_valid / out_stall  out_doc_number, out_location,
//                                            out_list_end, out_malformed
//
// One transaction per cycle sustained on both sides while out_stall is low; an input
// transaction is written into the queue at its accepting edge and its result, if any,
// is loaded into the result register when it is decoded from the queue head.
// The rate is set by the decode step in the back end
// (64-bit post count increment and compare, 32-bit running sum).
// rst_n is synchronous, active low; it empties the queue and clears decode state.
// in_stall rises only when the queue is full; out_stall holds the result register
// and, once the queue fills, pushes back to the input.
module posting_list_delta_decoder_core import plde_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_target_doc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_doc_number,
  output logic [31:0] out_location,
  output logic        out_list_end,
  output logic        out_malformed
);

  item_t   in_item;    // classified input transaction
  item_t   q_head;
  logic    q_full;
  logic    q_not_empty;
  logic    q_push;
  logic    q_pop;
  result_t res;

  // front end: byte classification only, no state
  plde_front u_front (
    .operation  (in_operation),
    .data_byte  (in_data_byte),
    .target_doc (in_target_doc),
    .item       (in_item)
  );

  // stall comes from registered fill level only
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  plde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back end: header parse, value assembly, posting update, result register
  plde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (res)
  );

  assign out_doc_number = res.doc_number;
  assign out_location   = res.location;
  assign out_list_end   = res.list_end;
  assign out_malformed  = res.malformed;

endmodule
